/* rtl/diff_drive_heading_tracker_macros.svh */
// assertion macros for the heading tracker
`ifndef DIFF_DRIVE_HEADING_TRACKER_MACROS_SVH
`define DIFF_DRIVE_HEADING_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define DHT_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("heading tracker check failed");
`define DHT_ASSERT_NR(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("heading tracker check failed");
`else
`define DHT_ASSERT(lbl, ck, rs, prop)
`define DHT_ASSERT_NR(lbl, ck, prop)
`endif
`endif

/* rtl/dht_pkg.sv */
// constants and helpers for the heading tracker
`default_nettype none
package dht_pkg;

  localparam logic [2:0] REG_MAX_FWD   = 3'd0;
  localparam logic [2:0] REG_MAX_YAW   = 3'd1;
  localparam logic [2:0] REG_HEAD_GAIN = 3'd2;
  localparam logic [2:0] REG_FF_GAIN   = 3'd3;
  localparam logic [2:0] REG_TRACK     = 3'd4;
  localparam logic [2:0] REG_WHEEL_MAX = 3'd5;

  localparam logic [30:0] RST_MAX_FWD   = 31'd98304;
  localparam logic [30:0] RST_MAX_YAW   = 31'd131072;
  localparam logic [31:0] RST_HEAD_GAIN = 32'd131072;
  localparam logic [31:0] RST_FF_GAIN   = 32'd65536;
  localparam logic [30:0] RST_TRACK     = 31'd32768;
  localparam logic [30:0] RST_WHEEL_MAX = 31'd131072;

  localparam int ANG_W = 21;
  localparam logic signed [ANG_W-1:0] PI_Q16      = 21'sd205887;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [ANG_W:0]   PI_W        = 22'sd205887;
  localparam logic signed [ANG_W:0]   TWO_PI_W    = 22'sd411774;
  localparam logic signed [32:0]      CORDIC_K_Q30 = 33'sd652032874;
  localparam logic [5:0] CORDIC_LAST = 6'd17;

  // wrap to [-pi, pi) for angles within a few turns
  function automatic logic signed [ANG_W-1:0] wrap_pi(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W:0] m;
    m = {a[ANG_W-1], a};
    for (int k = 0; k < 3; k++) begin
      if (m >= PI_W) begin
        m = m - TWO_PI_W;
      end else if (m < -PI_W) begin
        m = m + TWO_PI_W;
      end
    end
    return m[ANG_W-1:0];
  endfunction

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0: r = 17'd51472;
      5'd1: r = 17'd30386;
      5'd2: r = 17'd16055;
      5'd3: r = 17'd8150;
      5'd4: r = 17'd4091;
      5'd5: r = 17'd2047;
      5'd6: r = 17'd1024;
      5'd7: r = 17'd512;
      5'd8: r = 17'd256;
      5'd9: r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/diff_drive_heading_tracker.sv */
// heading tracker: sequencer around a shared divider, cordic and multiply-accumulate
//
//  channel   signals                                  role
//  sample    sample_valid/sample_stall + pose fields  reference pose in
//  cmd       cmd_valid/cmd_stall + command fields     speed commands out
//  cfg       cfg_valid/cfg_ready, cfg_index/cfg_data  register writes
//
// a priming sample skips the arithmetic and goes from idle straight to the output state
// a full sample runs four divisions, two cordic rotations, normalise and
// vectoring steps, three multiply-accumulate passes through one 34x18
// multiplier and one output step; normalise and vectoring are skipped with
// no reference motion, and the last division with a zero wheel track
// sample_stall is high while an item is in flight; cmd holds its transfer
// until taken, and a finished item waits while the output register is full
// reset restores register defaults and clears the stored pose
`default_nettype none
`include "diff_drive_heading_tracker_macros.svh"
module diff_drive_heading_tracker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [15:0] target_heading,
  input  wire logic        [30:0] step_time,
  input  wire logic signed [15:0] est_yaw,
  output logic                    cmd_valid,
  input  wire logic               cmd_stall,
  output logic signed [31:0]      linear_cmd,
  output logic signed [31:0]      angular_cmd,
  output logic                    primed_only,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_DIVY, S_DIVW, S_ROT1, S_PROJ, S_NORM, S_VEC,
    S_ROT2, S_VC, S_WZ, S_CAP, S_OUT
  } state_t;

  localparam logic [5:0] DIV_LAST = 6'd49;
  localparam logic [5:0] MAC_LAST = 6'd6;
  localparam logic signed [51:0] NORM_LIM = 52'sd1099511627776;
  localparam logic signed [85:0] RND30 = 86'sd536870912;
  localparam logic signed [85:0] RND16 = 86'sd32768;
  localparam logic signed [49:0] I32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] I32_MIN = -50'sd2147483648;

  state_t state;
  logic [5:0] cnt;

  logic        [30:0] max_forward_speed, max_yaw_rate, wheel_track, max_wheel_speed;
  logic signed [31:0] heading_gain, yaw_feedforward_gain;

  logic               have_previous;
  logic signed [31:0] last_x, last_y;
  logic signed [15:0] last_heading;

  logic signed [32:0] dx, dy;
  logic signed [16:0] dh;
  logic        [30:0] dt_q;
  logic signed [15:0] yaw_q;
  logic               prime;

  logic signed [49:0] vxw, vyw, wz;
  logic signed [31:0] wref;
  logic signed [32:0] cs_c, cs_s, ch;
  logic signed [51:0] vb;
  logic signed [20:0] he;
  logic signed [33:0] vc;
  logic        [48:0] cap;

  logic signed [51:0] cr_x, cr_y;
  logic signed [20:0] cr_z;
  logic               cr_neg;

  logic [48:0] dv_quo;
  logic [31:0] dv_rem;
  logic [30:0] dv_den;
  logic        dv_neg;

  logic signed [85:0] acc;

  // shared angle terms
  logic signed [20:0] yawq, dh8, wrap_dh;
  assign yawq    = {{2{yaw_q[15]}}, yaw_q, 3'b000};
  assign dh8     = {dh[16], dh, 3'b000};
  assign wrap_dh = dht_pkg::wrap_pi(dh8);

  // divider
  logic signed [49:0] div_num, div_mag, q_res, wref_cl;
  logic        [30:0] div_den;
  logic        [31:0] rem_sh, rem_n;
  logic               rem_ge;
  logic        [48:0] quo_n;
  logic signed [34:0] head_full;
  logic        [30:0] head31;
  logic        [33:0] abs_vc;

  assign abs_vc    = vc[33] ? 34'(-vc) : 34'(vc);
  assign head_full = $signed({4'b0, max_wheel_speed}) - $signed({1'b0, abs_vc});
  assign head31    = head_full[34] ? 31'd0 : head_full[30:0];

  always_comb begin
    case (state)
      S_DIVX:  div_num = {dx[32], dx, 16'b0};
      S_DIVY:  div_num = {dy[32], dy, 16'b0};
      S_DIVW:  div_num = {{13{wrap_dh[20]}}, wrap_dh, 16'b0};
      S_CAP:   div_num = {2'b00, head31, 17'b0};
      default: div_num = '0;
    endcase
  end
  assign div_den = (state == S_CAP) ? wheel_track : dt_q;
  assign div_mag = div_num[49] ? -div_num : div_num;
  assign rem_sh  = {dv_rem[30:0], dv_quo[48]};
  assign rem_ge  = rem_sh >= {1'b0, dv_den};
  assign rem_n   = rem_ge ? rem_sh - {1'b0, dv_den} : rem_sh;
  assign quo_n   = {dv_quo[47:0], rem_ge};
  assign q_res   = dv_neg ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
  assign wref_cl = (q_res > I32_MAX) ? I32_MAX : ((q_res < I32_MIN) ? I32_MIN : q_res);

  // cordic
  logic signed [20:0] rot_ang, rot_w, rot_z;
  logic               rot_neg, up, rot_mode;
  logic        [4:0]  it;
  logic signed [51:0] sx, sy, cx_n, cy_n;
  logic signed [20:0] at, cz_n;
  logic signed [32:0] cx_o, cy_o;

  assign rot_ang = (state == S_ROT1) ? yawq : he;
  assign rot_w   = dht_pkg::wrap_pi(rot_ang);
  always_comb begin
    rot_z   = rot_w;
    rot_neg = 1'b0;
    if (rot_w > dht_pkg::HALF_PI_Q16) begin
      rot_z   = rot_w - dht_pkg::PI_Q16;
      rot_neg = 1'b1;
    end else if (rot_w < -dht_pkg::HALF_PI_Q16) begin
      rot_z   = rot_w + dht_pkg::PI_Q16;
      rot_neg = 1'b1;
    end
  end

  assign it       = cnt[4:0] - 5'd1;
  assign rot_mode = (state != S_VEC);
  assign up       = rot_mode ? !cr_z[20] : cr_y[51];
  assign sx       = cr_y >>> it;
  assign sy       = cr_x >>> it;
  assign at       = $signed({4'b0, dht_pkg::atan_q16(it)});
  assign cx_n     = up ? cr_x - sx : cr_x + sx;
  assign cy_n     = up ? cr_y + sy : cr_y - sy;
  assign cz_n     = up ? cr_z - at : cr_z + at;
  assign cx_o     = cr_neg ? 33'(-cx_n) : cx_n[32:0];
  assign cy_o     = cr_neg ? 33'(-cy_n) : cy_n[32:0];

  logic norm_go;
  assign norm_go = (cr_x < NORM_LIM) && (cr_y < NORM_LIM) && (cr_y > -NORM_LIM);

  // multiply-accumulate
  logic signed [33:0] ma;
  logic signed [49:0] mb;
  logic signed [17:0] mchunk;
  logic signed [51:0] prod;
  logic signed [85:0] prod_x, prod_sh, acc_next;
  logic               term;
  logic [1:0]         chunk;
  logic signed [51:0] vmax_s;
  logic signed [31:0] vc1;

  assign vmax_s = $signed({21'b0, max_forward_speed});
  always_comb begin
    if (vb > vmax_s) begin
      vc1 = $signed({1'b0, max_forward_speed});
    end else if (vb < -vmax_s) begin
      vc1 = -$signed({1'b0, max_forward_speed});
    end else begin
      vc1 = vb[31:0];
    end
  end

  always_comb begin
    case (cnt[2:0])
      3'd1: begin term = 1'b0; chunk = 2'd0; end
      3'd2: begin term = 1'b0; chunk = 2'd1; end
      3'd3: begin term = 1'b0; chunk = 2'd2; end
      3'd4: begin term = 1'b1; chunk = 2'd0; end
      3'd5: begin term = 1'b1; chunk = 2'd1; end
      3'd6: begin term = 1'b1; chunk = 2'd2; end
      default: begin term = 1'b0; chunk = 2'd0; end
    endcase
  end

  always_comb begin
    case (state)
      S_PROJ: begin
        ma = term ? {cs_s[32], cs_s} : {cs_c[32], cs_c};
        mb = term ? vyw : vxw;
      end
      S_VC: begin
        ma = term ? 34'sd0 : {{2{vc1[31]}}, vc1};
        mb = term ? 50'sd0 : {{17{ch[32]}}, ch};
      end
      S_WZ: begin
        ma = term ? {{2{wref[31]}}, wref} : {{13{he[20]}}, he};
        mb = term ? {{18{yaw_feedforward_gain[31]}}, yaw_feedforward_gain}
                  : {{18{heading_gain[31]}}, heading_gain};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    case (chunk)
      2'd0:    mchunk = $signed({1'b0, mb[16:0]});
      2'd1:    mchunk = $signed({1'b0, mb[33:17]});
      2'd2:    mchunk = $signed({{2{mb[49]}}, mb[49:34]});
      default: mchunk = '0;
    endcase
  end
  assign prod   = ma * mchunk;
  assign prod_x = {{34{prod[51]}}, prod};
  always_comb begin
    case (chunk)
      2'd0:    prod_sh = prod_x;
      2'd1:    prod_sh = prod_x <<< 17;
      2'd2:    prod_sh = prod_x <<< 34;
      default: prod_sh = '0;
    endcase
  end
  assign acc_next = acc + prod_sh;

  // final limits
  logic [30:0]        cap_lim;
  logic signed [49:0] cap_s, wmax_s, wz1, wz2;
  logic signed [33:0] vmax34, vc_o;
  assign cap_lim = (cap > {18'b0, max_yaw_rate}) ? max_yaw_rate : cap[30:0];
  assign cap_s   = $signed({19'b0, cap_lim});
  assign wmax_s  = $signed({19'b0, max_yaw_rate});
  assign vmax34  = $signed({3'b0, max_forward_speed});
  assign wz1 = (wz > cap_s) ? cap_s : ((wz < -cap_s) ? -cap_s : wz);
  assign wz2 = (wz1 > wmax_s) ? wmax_s : ((wz1 < -wmax_s) ? -wmax_s : wz1);
  assign vc_o = (vc > vmax34) ? vmax34 : ((vc < -vmax34) ? -vmax34 : vc);

  assign sample_stall = (state != S_IDLE);
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      cnt                  <= '0;
      have_previous        <= 1'b0;
      last_x               <= '0;
      last_y               <= '0;
      last_heading         <= '0;
      cmd_valid            <= 1'b0;
      max_forward_speed    <= dht_pkg::RST_MAX_FWD;
      max_yaw_rate         <= dht_pkg::RST_MAX_YAW;
      heading_gain         <= dht_pkg::RST_HEAD_GAIN;
      yaw_feedforward_gain <= dht_pkg::RST_FF_GAIN;
      wheel_track          <= dht_pkg::RST_TRACK;
      max_wheel_speed      <= dht_pkg::RST_WHEEL_MAX;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dht_pkg::REG_MAX_FWD:   max_forward_speed    <= cfg_data[30:0];
          dht_pkg::REG_MAX_YAW:   max_yaw_rate         <= cfg_data[30:0];
          dht_pkg::REG_HEAD_GAIN: heading_gain         <= cfg_data;
          dht_pkg::REG_FF_GAIN:   yaw_feedforward_gain <= cfg_data;
          dht_pkg::REG_TRACK:     wheel_track          <= cfg_data[30:0];
          dht_pkg::REG_WHEEL_MAX: max_wheel_speed      <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (cmd_valid && !cmd_stall && state != S_OUT) begin
        cmd_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            last_x        <= target_x;
            last_y        <= target_y;
            last_heading  <= target_heading;
            have_previous <= 1'b1;
            dx    <= {target_x[31], target_x} - {last_x[31], last_x};
            dy    <= {target_y[31], target_y} - {last_y[31], last_y};
            dh    <= {target_heading[15], target_heading} - {last_heading[15], last_heading};
            dt_q  <= step_time;
            yaw_q <= est_yaw;
            cnt   <= '0;
            if (!have_previous || step_time == 31'd0) begin
              prime <= 1'b1;
              state <= S_OUT;
            end else begin
              prime <= 1'b0;
              state <= S_DIVX;
            end
          end
        end

        S_DIVX, S_DIVY, S_DIVW, S_CAP: begin
          if (cnt == 6'd0) begin
            if (state == S_CAP && wheel_track == 31'd0) begin
              cap   <= '0;
              state <= S_OUT;
            end else begin
              dv_quo <= div_mag[48:0];
              dv_rem <= '0;
              dv_den <= div_den;
              dv_neg <= div_num[49];
              cnt    <= cnt + 6'd1;
            end
          end else begin
            dv_quo <= quo_n;
            dv_rem <= rem_n;
            if (cnt == DIV_LAST) begin
              cnt <= '0;
              case (state)
                S_DIVX: begin vxw <= q_res; state <= S_DIVY; end
                S_DIVY: begin vyw <= q_res; state <= S_DIVW; end
                S_DIVW: begin wref <= wref_cl[31:0]; state <= S_ROT1; end
                default: begin cap <= quo_n; state <= S_OUT; end
              endcase
            end else begin
              cnt <= cnt + 6'd1;
            end
          end
        end

        S_ROT1, S_ROT2, S_VEC: begin
          if (cnt == 6'd0) begin
            cr_x   <= {{19{dht_pkg::CORDIC_K_Q30[32]}}, dht_pkg::CORDIC_K_Q30};
            cr_y   <= '0;
            cr_z   <= rot_z;
            cr_neg <= rot_neg;
            cnt    <= 6'd1;
          end else begin
            cr_x <= cx_n;
            cr_y <= cy_n;
            cr_z <= cz_n;
            if (cnt == dht_pkg::CORDIC_LAST) begin
              cnt <= '0;
              case (state)
                S_ROT1: begin cs_c <= cx_o; cs_s <= cy_o; state <= S_PROJ; end
                S_ROT2: begin ch <= cx_o; state <= S_VC; end
                default: begin
                  he    <= dht_pkg::wrap_pi(cz_n - yawq);
                  state <= S_ROT2;
                end
              endcase
            end else begin
              cnt <= cnt + 6'd1;
            end
          end
        end

        S_NORM: begin
          if (norm_go) begin
            cr_x <= cr_x <<< 1;
            cr_y <= cr_y <<< 1;
          end else begin
            cnt   <= 6'd1;
            state <= S_VEC;
          end
        end

        S_PROJ, S_VC, S_WZ: begin
          if (cnt == 6'd0) begin
            acc <= (state == S_WZ) ? RND16 : RND30;
            cnt <= 6'd1;
          end else begin
            acc <= acc_next;
            if (cnt == MAC_LAST) begin
              cnt <= '0;
              case (state)
                S_PROJ: begin
                  vb <= acc_next[81:30];
                  if (vxw == 50'sd0 && vyw == 50'sd0) begin
                    he    <= dht_pkg::wrap_pi(-yawq);
                    state <= S_ROT2;
                  end else begin
                    cr_neg <= 1'b0;
                    if (vxw[49]) begin
                      cr_z <= vyw[49] ? -dht_pkg::PI_Q16 : dht_pkg::PI_Q16;
                      cr_x <= -{{2{vxw[49]}}, vxw};
                      cr_y <= -{{2{vyw[49]}}, vyw};
                    end else begin
                      cr_z <= '0;
                      cr_x <= {{2{vxw[49]}}, vxw};
                      cr_y <= {{2{vyw[49]}}, vyw};
                    end
                    state <= S_NORM;
                  end
                end
                S_VC: begin vc <= acc_next[63:30]; state <= S_WZ; end
                default: begin wz <= acc_next[65:16]; state <= S_CAP; end
              endcase
            end else begin
              cnt <= cnt + 6'd1;
            end
          end
        end

        S_OUT: begin
          if (!cmd_valid || !cmd_stall) begin
            cmd_valid   <= 1'b1;
            primed_only <= prime;
            linear_cmd  <= prime ? 32'sd0 : vc_o[31:0];
            angular_cmd <= prime ? 32'sd0 : wz2[31:0];
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `DHT_ASSERT(a_busy_after_take, clk, rst, (sample_valid && !sample_stall) |=> sample_stall)
  `DHT_ASSERT(a_prime_zero, clk, rst, (cmd_valid && primed_only) |-> (linear_cmd == 32'sd0 && angular_cmd == 32'sd0))
  `DHT_ASSERT(a_lin_limit, clk, rst, cmd_valid |-> ($signed({1'b0, linear_cmd[31] ? -linear_cmd : linear_cmd}) <= $signed({2'b0, max_forward_speed})))
  `DHT_ASSERT(a_cnt_range, clk, rst, cnt <= DIV_LAST)
  `DHT_ASSERT(a_out_from_seq, clk, rst, $rose(cmd_valid) |-> $past(state) == S_OUT)

endmodule
`default_nettype wire
